>>> sv/hftd_pkg.sv
// ----------------------------------------------------------------------------
// hftd_pkg: shared types and tables for the text frame decoder
// Control word layout, datapath handshake structs, the microcode program and
// the static prefix-code lookup table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hftd_pkg;

   // Frame geometry. Bits 0..71 are kept in one vector, frame bit 0 at the top.
   localparam int unsigned FrameBits    = 72;
   localparam int unsigned TextLastBit  = 71;
   localparam int unsigned CodeLimit    = 72;
   localparam int unsigned FirstTextBit = 2;
   localparam int unsigned MaxCodeLen   = 8;
   localparam int unsigned ScanGroup    = 8;
   localparam int unsigned PosWidth     = 7;

   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_UNSUP  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
   localparam logic [6:0] CHAR_LT      = 7'h3C;
   localparam logic [6:0] CHAR_GT      = 7'h3E;
   localparam logic [6:0] CHAR_NONE    = 7'h00;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_TYPE,
      ST_SCAN,
      ST_TEXT,
      ST_DEC,
      ST_MARK,
      ST_LT,
      ST_GT,
      ST_DONE_CHK,
      ST_EMPTY,
      ST_UNSUP
   } step_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_SCAN,
      ACT_ADVANCE
   } act_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_CHAR,
      EM_LT,
      EM_GT,
      EM_EMPTY,
      EM_UNSUP
   } emit_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NOT_VALID,
      C_TYPE_BAD,
      C_SCAN_BUSY,
      C_NO_TEXT,
      C_MORE_TEXT,
      C_NO_MARK,
      C_HAD_TEXT,
      C_NEVER
   } cond_type;

   typedef struct packed {
      act_type  act;
      emit_type emit;
      cond_type cond;
      step_type jump;
   } uword_type;

   typedef struct packed {
      act_type  act;
      emit_type emit;
      logic     fire;
   } ctl_type;

   typedef struct packed {
      logic type_bad;
      logic scan_busy;
      logic no_text;
      logic more_text;
      logic no_mark;
      logic had_text;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic [6:0] ch;
      logic [3:0] len;
   } code_type;

   // Microcode program. A true condition jumps, otherwise the step counter
   // moves on by one.
   function automatic uword_type hftd_ucode(input step_type step);
      uword_type w;
      unique case (step)
         ST_WAIT:     w = '{ACT_LOAD,    EM_NONE,  C_NOT_VALID, ST_WAIT};
         ST_TYPE:     w = '{ACT_NONE,    EM_NONE,  C_TYPE_BAD,  ST_UNSUP};
         ST_SCAN:     w = '{ACT_SCAN,    EM_NONE,  C_SCAN_BUSY, ST_SCAN};
         ST_TEXT:     w = '{ACT_NONE,    EM_NONE,  C_NO_TEXT,   ST_MARK};
         ST_DEC:      w = '{ACT_ADVANCE, EM_CHAR,  C_MORE_TEXT, ST_DEC};
         ST_MARK:     w = '{ACT_NONE,    EM_NONE,  C_NO_MARK,   ST_DONE_CHK};
         ST_LT:       w = '{ACT_NONE,    EM_LT,    C_NEVER,     ST_WAIT};
         ST_GT:       w = '{ACT_NONE,    EM_GT,    C_ALWAYS,    ST_WAIT};
         ST_DONE_CHK: w = '{ACT_NONE,    EM_NONE,  C_HAD_TEXT,  ST_WAIT};
         ST_EMPTY:    w = '{ACT_NONE,    EM_EMPTY, C_ALWAYS,    ST_WAIT};
         ST_UNSUP:    w = '{ACT_NONE,    EM_UNSUP, C_ALWAYS,    ST_WAIT};
         default:     w = '{ACT_NONE,    EM_NONE,  C_ALWAYS,    ST_WAIT};
      endcase
      return w;
   endfunction

   // The code is complete and prefix-free, so exactly one entry is a prefix
   // of any eight-bit window.
   function automatic code_type hftd_lookup(input logic [MaxCodeLen-1:0] win);
      code_type r;
      case (win) inside
         8'b01??????: r = '{7'h20, 4'd2};
         8'b100?????: r = '{7'h45, 4'd3};
         8'b1101????: r = '{7'h54, 4'd4};
         8'b0011????: r = '{7'h41, 4'd4};
         8'b11111???: r = '{7'h4F, 4'd5};
         8'b11100???: r = '{7'h49, 4'd5};
         8'b10111???: r = '{7'h4E, 4'd5};
         8'b10100???: r = '{7'h53, 4'd5};
         8'b00011???: r = '{7'h48, 4'd5};
         8'b00000???: r = '{7'h52, 4'd5};
         8'b111011??: r = '{7'h44, 4'd6};
         8'b110011??: r = '{7'h4C, 4'd6};
         8'b110001??: r = '{7'h43, 4'd6};
         8'b101101??: r = '{7'h55, 4'd6};
         8'b101011??: r = '{7'h4D, 4'd6};
         8'b001011??: r = '{7'h57, 4'd6};
         8'b001001??: r = '{7'h46, 4'd6};
         8'b000101??: r = '{7'h47, 4'd6};
         8'b000011??: r = '{7'h59, 4'd6};
         8'b1111011?: r = '{7'h50, 4'd7};
         8'b1111001?: r = '{7'h42, 4'd7};
         8'b1110100?: r = '{7'h2E, 4'd7};
         8'b1100101?: r = '{7'h56, 4'd7};
         8'b1100100?: r = '{7'h4B, 4'd7};
         8'b1100001?: r = '{7'h2D, 4'd7};
         8'b1100000?: r = '{7'h2B, 4'd7};
         8'b1011001?: r = '{7'h3F, 4'd7};
         8'b1011000?: r = '{7'h21, 4'd7};
         8'b1010101?: r = '{7'h22, 4'd7};
         8'b1010100?: r = '{7'h58, 4'd7};
         8'b0010101?: r = '{7'h30, 4'd7};
         8'b0010100?: r = '{7'h4A, 4'd7};
         8'b0010001?: r = '{7'h31, 4'd7};
         8'b0010000?: r = '{7'h51, 4'd7};
         8'b0001001?: r = '{7'h32, 4'd7};
         8'b0001000?: r = '{7'h5A, 4'd7};
         8'b0000101?: r = '{7'h33, 4'd7};
         8'b0000100?: r = '{7'h35, 4'd7};
         8'b11110101: r = '{7'h34, 4'd8};
         8'b11110100: r = '{7'h39, 4'd8};
         8'b11110001: r = '{7'h38, 4'd8};
         8'b11110000: r = '{7'h36, 4'd8};
         8'b11101011: r = '{7'h37, 4'd8};
         8'b11101010: r = '{7'h2F, 4'd8};
         default:     r = '{CHAR_UNKNOWN, 4'd1};
      endcase
      return r;
   endfunction

endpackage

>>> sv/hftd_datapath.sv
// ----------------------------------------------------------------------------
// hftd_datapath: frame registers, end scan, code match and result register
// Carries out the action and emission named by the current control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hftd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  hftd_pkg::ctl_type  ctl,
   input  logic [63:0]        req_frame_head,
   input  logic [9:0]         req_frame_tail,
   input  logic               rsp_stall,
   output hftd_pkg::stat_type stat,
   output logic               rsp_valid,
   output logic [6:0]         rsp_char_code,
   output logic [1:0]         rsp_kind,
   output logic               rsp_last
);
   import hftd_pkg::*;

   logic [FrameBits-1:0] frame_w;
   logic [FrameBits-1:0] scan_ff;
   logic [FrameBits-1:0] dec_ff;
   logic [PosWidth-1:0]  end_ff;
   logic [PosWidth-1:0]  pos_ff;
   logic                 type_bad_ff;
   logic                 mark_ff;

   logic                 zero_found;
   logic [2:0]           zero_idx;
   code_type             code;
   logic                 fit;
   logic [3:0]           adv;
   logic [6:0]           dec_char;
   logic [PosWidth-1:0]  pos_next;
   logic                 more_text;

   logic                 rsp_valid_ff;
   logic [6:0]           char_ff;
   logic [1:0]           kind_ff;
   logic                 last_ff;
   logic [6:0]           char_in;
   logic [1:0]           kind_in;
   logic                 last_in;
   logic                 emit_go;

   // Frame bit n sits at index FrameBits-1-n; bit 72 is not used.
   assign frame_w = {req_frame_head, req_frame_tail[9:2]};

   // The scan register holds the bit at the current end position in its
   // lowest place, with lower frame bits above it.
   always_comb begin
      zero_found = 1'b0;
      zero_idx   = '0;
      for (int j = 0; j < ScanGroup; j++) begin
         if (!zero_found && !scan_ff[j]) begin
            zero_found = 1'b1;
            zero_idx   = 3'(j);
         end
      end
   end

   always_comb begin
      code      = hftd_lookup(dec_ff[FrameBits-1 -: MaxCodeLen]);
      fit       = ({1'b0, pos_ff} + 8'(code.len)) <= 8'(CodeLimit);
      adv       = fit ? code.len : 4'd1;
      dec_char  = fit ? code.ch : CHAR_UNKNOWN;
      pos_next  = pos_ff + PosWidth'(adv);
      more_text = pos_next < end_ff;
   end

   assign emit_go = ctl.fire && (ctl.emit != EM_NONE);

   assign stat.type_bad  = type_bad_ff;
   assign stat.scan_busy = !zero_found;
   assign stat.no_text   = pos_ff >= end_ff;
   assign stat.more_text = more_text;
   assign stat.no_mark   = !mark_ff;
   assign stat.had_text  = end_ff > PosWidth'(FirstTextBit);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         case (ctl.act)
            ACT_LOAD: begin
               scan_ff     <= frame_w;
               dec_ff      <= frame_w << FirstTextBit;
               end_ff      <= PosWidth'(TextLastBit);
               pos_ff      <= PosWidth'(FirstTextBit);
               type_bad_ff <= !(req_frame_head[63] && !req_frame_head[62]);
               mark_ff     <= req_frame_tail[0];
            end
            ACT_SCAN: begin
               if (zero_found) begin
                  end_ff <= end_ff - PosWidth'(zero_idx);
               end else begin
                  end_ff  <= end_ff - PosWidth'(ScanGroup);
                  scan_ff <= scan_ff >> ScanGroup;
               end
            end
            ACT_ADVANCE: begin
               dec_ff <= dec_ff << adv;
               pos_ff <= pos_next;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ctl.emit)
         EM_CHAR: begin
            char_in = dec_char;
            kind_in = KIND_CHAR;
            last_in = !more_text && !mark_ff;
         end
         EM_LT: begin
            char_in = CHAR_LT;
            kind_in = KIND_CHAR;
            last_in = 1'b0;
         end
         EM_GT: begin
            char_in = CHAR_GT;
            kind_in = KIND_CHAR;
            last_in = 1'b1;
         end
         EM_EMPTY: begin
            char_in = CHAR_NONE;
            kind_in = KIND_EMPTY;
            last_in = 1'b1;
         end
         EM_UNSUP: begin
            char_in = CHAR_NONE;
            kind_in = KIND_UNSUP;
            last_in = 1'b1;
         end
         default: begin
            char_in = CHAR_NONE;
            kind_in = KIND_CHAR;
            last_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         char_ff <= char_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_last      = last_ff;

endmodule

>>> sv/huffman_text_frame_decode.sv
// ----------------------------------------------------------------------------
// huffman_text_frame_decode: static prefix-code text frame decoder
// Takes one 74-bit frame per request and returns its decoded characters, one
// per response, with last set on the final one. A frame whose type bits are
// not 1 then 0 gives a single unsupported response, and a frame with no text
// and no mark gives a single empty response. A supported frame runs these
// steps: accept, check the type, scan for the end of the text (eight frame
// bits a cycle), test for text, one response per decoded character, test the
// mark, then a < response and a > response if the mark is set, or a closing
// check if it is not. The rate is set by the microcode sequencer, which runs
// one control word per cycle while no emitting step is held by a full output
// register, and matches one code per step. The next request is taken once
// the previous frame's last response is in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_text_frame_decode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_frame_head,
   input  logic [9:0]  req_frame_tail,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_char_code,
   output logic [1:0]  rsp_kind,
   output logic        rsp_last
);
   import hftd_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type uword;
   ctl_type   ctl;
   stat_type  stat;
   logic      ok;
   logic      cond;

   hftd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_frame_head (req_frame_head),
      .req_frame_tail (req_frame_tail),
      .rsp_stall      (rsp_stall),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_kind       (rsp_kind),
      .rsp_last       (rsp_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      uword = hftd_ucode(step_ff);

      case (uword.cond)
         C_ALWAYS:    cond = 1'b1;
         C_NOT_VALID: cond = !req_valid;
         C_TYPE_BAD:  cond = stat.type_bad;
         C_SCAN_BUSY: cond = stat.scan_busy;
         C_NO_TEXT:   cond = stat.no_text;
         C_MORE_TEXT: cond = stat.more_text;
         C_NO_MARK:   cond = stat.no_mark;
         C_HAD_TEXT:  cond = stat.had_text;
         default:     cond = 1'b0;
      endcase

      // A step that emits waits until the output register can take it.
      ok        = (uword.emit == EM_NONE) || stat.out_free;
      req_stall = (uword.act != ACT_LOAD);

      ctl.act  = uword.act;
      ctl.emit = uword.emit;
      ctl.fire = ok && ((uword.act != ACT_LOAD) || req_valid);

      if (!ok) begin
         step_in = step_ff;
      end else if (cond) begin
         step_in = uword.jump;
      end else begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

`ifndef SYNTHESIS
   a_accept_then_type: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (step_ff == ST_TYPE))
      else $error("accepted request did not move on to the type check");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_CHAR)) |-> ((rsp_char_code == CHAR_NONE) && rsp_last))
      else $error("status response without zero code or last flag");

   a_idle_pending_last: assert property (@(posedge clock) disable iff (reset)
      ((step_ff == ST_WAIT) && rsp_valid) |-> rsp_last)
      else $error("frame closed while a non-final response is pending");
`endif

endmodule
